FILE: rtl/core/cdfe_pkg.sv
// cdfe_pkg: shared types, codes and the CRC-16/CCITT-FALSE byte step for the
// chunked download frame encoder. No dependencies; used by every module of the block.
package cdfe_pkg;

   // request command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // register indexes, decoded from paddr[2]
   localparam logic CSR_IDX_DIRECTION = 1'b0;
   localparam logic CSR_IDX_MAX_CHUNK = 1'b1;

   // register reset values
   localparam logic [7:0] DIRECTION_RESET = 8'd127;
   localparam logic [9:0] MAX_CHUNK_RESET = 10'd256;

   // frame constants
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam int unsigned JOB_BYTES = 6;
   localparam int unsigned JOB_IDX_W = 3;

   // input request
   typedef struct packed {
      logic        cmd;
      logic [15:0] command_length;
      logic [7:0]  data_byte;
   } req_type;

   // one output byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
      logic       command_end;
   } rsp_type;

   // byte group produced by one request, handed from front to back
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [JOB_IDX_W-1:0]      last_idx;
      logic                      fend_valid;
      logic [JOB_IDX_W-1:0]      fend_idx;
      logic                      cend;
   } job_type;

   // CRC-16/CCITT-FALSE (poly 0x1021) update over one byte
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] din);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c = c ^ {8'h00, din};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {3'b000, c[7:0], 5'b00000};
      return c;
   endfunction

endpackage

FILE: rtl/core/cdfe_front.sv
// cdfe_front: accepts requests, tracks command/chunk counters and the running CRC,
// and builds the byte group each request produces. Depends on cdfe_pkg.
module cdfe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          direction_byte,
   input  logic [9:0]          max_chunk_size,
   input  logic                accept,
   input  cdfe_pkg::req_type   req,
   output logic                job_push,
   output cdfe_pkg::job_type   job
);

   logic [15:0] cmd_rem_ff, cmd_rem_in;
   logic [9:0]  chunk_rem_ff, chunk_rem_in;
   logic [15:0] crc_ff, crc_in;
   logic        open_ff, open_in;

   logic [9:0]  limit;
   logic [15:0] rem;
   logic        last;
   logic [9:0]  len;
   logic [7:0]  h0;
   logic [7:0]  h1;
   logic [15:0] rem_next;
   logic [15:0] open_crc;
   logic [15:0] data_crc;
   logic [9:0]  chunk_dec;
   logic        done;
   logic        job_valid;

   // chunk opening: length, header and header CRC
   always_comb begin
      limit    = (max_chunk_size == 10'd0) ? 10'd1 : max_chunk_size;
      rem      = (req.cmd == cdfe_pkg::CMD_START) ? req.command_length : cmd_rem_ff;
      last     = rem <= {6'd0, limit};
      len      = last ? rem[9:0] : limit;
      h0       = {5'd0, ~last, len[9:8]};
      h1       = len[7:0];
      rem_next = rem - {6'd0, len};
      open_crc = cdfe_pkg::crc_update(cdfe_pkg::crc_update(cdfe_pkg::CRC_INIT, h0), h1);
      data_crc = cdfe_pkg::crc_update(crc_ff, req.data_byte);
      chunk_dec = chunk_rem_ff - 10'd1;
      done     = cmd_rem_ff == 16'd0;
   end

   // byte group and next state per request kind
   always_comb begin
      cmd_rem_in   = cmd_rem_ff;
      chunk_rem_in = chunk_rem_ff;
      crc_in       = crc_ff;
      open_in      = open_ff;
      job_valid    = 1'b0;
      job          = '0;
      case (req.cmd)
         cdfe_pkg::CMD_START: begin
            job_valid    = 1'b1;
            job.bytes[0] = direction_byte;
            job.bytes[1] = h0;
            job.bytes[2] = h1;
            job.bytes[3] = open_crc[15:8];
            job.bytes[4] = open_crc[7:0];
            job.fend_idx = 3'd4;
            job.cend     = 1'b1;
            cmd_rem_in   = rem_next;
            chunk_rem_in = len;
            crc_in       = open_crc;
            if (len == 10'd0) begin
               // empty command: whole frame at once, nothing stays open
               job.last_idx   = 3'd4;
               job.fend_valid = 1'b1;
               open_in        = 1'b0;
            end else begin
               job.last_idx   = 3'd2;
               open_in        = 1'b1;
            end
         end
         cdfe_pkg::CMD_DATA: begin
            if (open_ff && chunk_rem_ff != 10'd0) begin
               job_valid    = 1'b1;
               job.bytes[0] = req.data_byte;
               crc_in       = data_crc;
               chunk_rem_in = chunk_dec;
               if (chunk_dec == 10'd0) begin
                  // chunk complete: CRC, then next chunk's opening if any
                  job.bytes[1]   = data_crc[15:8];
                  job.bytes[2]   = data_crc[7:0];
                  job.bytes[3]   = direction_byte;
                  job.bytes[4]   = h0;
                  job.bytes[5]   = h1;
                  job.fend_valid = 1'b1;
                  job.fend_idx   = 3'd2;
                  job.cend       = done;
                  if (done) begin
                     job.last_idx = 3'd2;
                     open_in      = 1'b0;
                  end else begin
                     job.last_idx = 3'd5;
                     chunk_rem_in = len;
                     crc_in       = open_crc;
                     cmd_rem_in   = rem_next;
                  end
               end
            end
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

   assign job_push = accept && job_valid;

   // command state
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_rem_ff   <= '0;
         chunk_rem_ff <= '0;
         crc_ff       <= cdfe_pkg::CRC_INIT;
         open_ff      <= 1'b0;
      end else if (accept) begin
         cmd_rem_ff   <= cmd_rem_in;
         chunk_rem_ff <= chunk_rem_in;
         crc_ff       <= crc_in;
         open_ff      <= open_in;
      end
   end

endmodule

FILE: rtl/core/cdfe_queue.sv
// cdfe_queue: short FIFO of byte groups between front and back.
// Depends on cdfe_pkg for the entry type.
module cdfe_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cdfe_pkg::job_type push_job,
   input  logic              pop,
   output cdfe_pkg::job_type head,
   output logic              empty,
   output logic              full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cdfe_pkg::job_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = count_ff == '0;
   assign full  = count_ff == CNT_FULL;
   assign head  = mem[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/cdfe_back.sv
// cdfe_back: walks the head byte group one byte per cycle into the output register
// while that register is free or rsp_ready is high. Depends on cdfe_pkg.
module cdfe_back (
   input  logic              clock,
   input  logic              reset,
   input  cdfe_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdfe_pkg::rsp_type rsp_payload
);

   logic [cdfe_pkg::JOB_IDX_W-1:0] idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   cdfe_pkg::rsp_type              out_ff, out_in;
   logic                           load;
   logic                           at_end;

   assign load   = !empty && (!valid_ff || rsp_ready);
   assign at_end = idx_ff == head.last_idx;
   assign pop    = load && at_end;

   // next byte and flags
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         valid_in             = 1'b1;
         out_in.out_byte      = head.bytes[idx_ff];
         out_in.run_last      = at_end;
         out_in.frame_end     = head.fend_valid && idx_ff == head.fend_idx;
         out_in.command_end   = head.fend_valid && idx_ff == head.fend_idx && head.cend;
         idx_in               = at_end ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule

FILE: rtl/core/chunked_download_frame_encoder_top.sv
// chunked_download_frame_encoder_top: configuration registers and the front/queue/back
// chain. Depends on cdfe_pkg, cdfe_front, cdfe_queue, cdfe_back.
//
//   port group   direction  carries
//   req_*        in         request: cmd, command_length, data_byte
//   rsp_*        out        one framed byte with run_last/frame_end/command_end
//   p* (APB)     in/out     direction_byte (addr 0), max_chunk_size (addr 4)
//
// A request is taken every cycle while the queue has room; it becomes 0 to 6 bytes.
// The back end sends one byte per cycle while rsp_ready allows, so a request's bytes go out
// in turn (one for a mid-chunk data byte, up to six at a chunk boundary).
// The output register frees the front: requests keep flowing while rsp_ready is low
// until the queue of QUEUE_DEPTH byte groups fills. Reset is synchronous and clears
// all command state and loads the register reset values; no clearing pass.
module chunked_download_frame_encoder_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdfe_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdfe_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [7:0]        direction_ff;
   logic [9:0]        max_chunk_ff;
   logic              accept;
   logic              job_push;
   cdfe_pkg::job_type job;
   cdfe_pkg::job_type head;
   logic              q_empty;
   logic              q_full;
   logic              q_pop;
   logic              csr_write;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= cdfe_pkg::DIRECTION_RESET;
         max_chunk_ff <= cdfe_pkg::MAX_CHUNK_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            cdfe_pkg::CSR_IDX_DIRECTION: direction_ff <= pwdata[7:0];
            cdfe_pkg::CSR_IDX_MAX_CHUNK: max_chunk_ff <= pwdata[9:0];
            default: direction_ff <= direction_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         cdfe_pkg::CSR_IDX_DIRECTION: prdata = {24'd0, direction_ff};
         cdfe_pkg::CSR_IDX_MAX_CHUNK: prdata = {22'd0, max_chunk_ff};
         default: prdata = '0;
      endcase
   end

   // request handshake
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   cdfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .direction_byte (direction_ff),
      .max_chunk_size (max_chunk_ff),
      .accept         (accept),
      .req            (req_payload),
      .job_push       (job_push),
      .job            (job)
   );

   cdfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   cdfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (q_empty),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: test/chunked_download_frame_encoder_top_tb.sv
// Self-checking testbench for chunked_download_frame_encoder_top: predicts every framed
// byte (direction, header, payload, CRC-16) of each request and checks the output stream.
// Depends on cdfe_pkg and the block's RTL only.
module chunked_download_frame_encoder_top_tb;

   localparam int SETTLE_CYCLES  = 16;
   localparam int STALL_LIMIT    = 3000;
   localparam int PHASE_REQUESTS = 50;

   // Expected framed byte stream, kept in step with the block's command state
   class frame_tracker;
      bit [7:0]  direction;
      bit [9:0]  max_chunk;
      bit [15:0] command_left;
      bit [9:0]  chunk_left;
      bit [15:0] crc;
      bit        command_open;
      cdfe_pkg::rsp_type frame_bytes_due[$];
      cdfe_pkg::rsp_type burst[$];
      int        mismatches;

      function new();
         direction    = cdfe_pkg::DIRECTION_RESET;
         max_chunk    = cdfe_pkg::MAX_CHUNK_RESET;
         command_left = '0;
         chunk_left   = '0;
         crc          = cdfe_pkg::CRC_INIT;
         command_open = 1'b0;
         mismatches   = 0;
      endfunction

      function int pending();
         return frame_bytes_due.size();
      endfunction

      function void write_reg(logic idx, logic [31:0] value);
         if (idx == cdfe_pkg::CSR_IDX_DIRECTION)
            direction = value[7:0];
         else
            max_chunk = value[9:0];
      endfunction

      // bitwise MSB-first CRC-16, poly 0x1021
      function bit [15:0] crc_byte(bit [15:0] c, bit [7:0] b);
         c = c ^ {b, 8'h00};
         for (int i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
         return c;
      endfunction

      function void push_byte(bit [7:0] b, bit fend, bit cend);
         cdfe_pkg::rsp_type r;
         r.out_byte    = b;
         r.run_last    = 1'b0;
         r.frame_end   = fend;
         r.command_end = cend;
         burst.push_back(r);
      endfunction

      // direction byte and header of a new chunk
      function void start_chunk();
         bit [15:0] limit;
         bit [15:0] len;
         bit [7:0]  h0;
         bit [7:0]  h1;
         limit = (max_chunk == 0) ? 16'd1 : {6'd0, max_chunk};
         if (command_left > limit) begin
            len = limit;
            h0  = {5'd0, 1'b1, len[9:8]};
         end else begin
            len = command_left;
            h0  = {6'd0, len[9:8]};
         end
         h1 = len[7:0];
         push_byte(direction, 1'b0, 1'b0);
         push_byte(h0, 1'b0, 1'b0);
         push_byte(h1, 1'b0, 1'b0);
         crc          = crc_byte(crc_byte(cdfe_pkg::CRC_INIT, h0), h1);
         chunk_left   = len[9:0];
         command_left = command_left - len;
      endfunction

      // CRC trailer, then either the command ends or the next chunk opens
      function void finish_chunk();
         bit done;
         done = (command_left == 0);
         push_byte(crc[15:8], 1'b0, 1'b0);
         push_byte(crc[7:0], 1'b1, done);
         if (done)
            command_open = 1'b0;
         else
            start_chunk();
      endfunction

      task note_request(cdfe_pkg::req_type r);
         burst.delete();
         if (r.cmd == cdfe_pkg::CMD_START) begin
            command_left = r.command_length;
            command_open = 1'b1;
            start_chunk();
            if (chunk_left == 0)
               finish_chunk();
         end else if (command_open && chunk_left != 0) begin
            push_byte(r.data_byte, 1'b0, 1'b0);
            crc        = crc_byte(crc, r.data_byte);
            chunk_left = chunk_left - 10'd1;
            if (chunk_left == 0)
               finish_chunk();
         end
         if (burst.size() > 0) begin
            burst[burst.size()-1].run_last = 1'b1;
            foreach (burst[i])
               frame_bytes_due.push_back(burst[i]);
         end
      endtask

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_response(cdfe_pkg::rsp_type got);
         cdfe_pkg::rsp_type want;
         if (frame_bytes_due.size() == 0) begin
            report($sformatf("unexpected byte %02h", got.out_byte));
            return;
         end
         want = frame_bytes_due.pop_front();
         if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, wanted %02h", got.out_byte, want.out_byte));
         if (got.run_last !== want.run_last)
            report($sformatf("run_last %b, wanted %b on byte %02h",
                             got.run_last, want.run_last, want.out_byte));
         if (got.frame_end !== want.frame_end)
            report($sformatf("frame_end %b, wanted %b on byte %02h",
                             got.frame_end, want.frame_end, want.out_byte));
         if (got.command_end !== want.command_end)
            report($sformatf("command_end %b, wanted %b on byte %02h",
                             got.command_end, want.command_end, want.out_byte));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid;
   logic              req_ready;
   cdfe_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   cdfe_pkg::rsp_type rsp_payload;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   frame_tracker tracker = new();
   int snd_idle_pct = 8;
   int rsp_idle_pct = 85;
   int hold_cycles  = 0;
   int stall_count  = 0;

   chunked_download_frame_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request(req_payload);
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_payload);
      end
   end

   // watchdog: cycles with no handshake and no register access
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: random back-pressure plus an optional long hold-off
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
         end else begin
            rsp_ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic cdfe_pkg::req_type make_req(logic cmd, logic [15:0] len,
                                                  logic [7:0] data);
      cdfe_pkg::req_type r;
      r.cmd            = cmd;
      r.command_length = len;
      r.data_byte      = data;
      return r;
   endfunction

   // offer one request and hold it until accepted
   task automatic send_request(input cdfe_pkg::req_type r);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_start(input logic [15:0] len);
      send_request(make_req(cdfe_pkg::CMD_START, len, 8'($urandom_range(255))));
   endtask

   task automatic send_data(input logic [7:0] data);
      send_request(make_req(cdfe_pkg::CMD_DATA, 16'($urandom_range(65535)), data));
   endtask

   // sender pauses until every expected byte is out, then lets the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.write_reg(idx, value);
      @(posedge clock);
   endtask

   // random traffic: mostly whole commands, some stray and truncated ones
   task automatic run_random(input int budget);
      int sent;
      int kind;
      int len;
      int cut;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(99);
         if (kind < 7) begin
            // stray byte, ignored unless a command is open
            send_data(8'($urandom_range(255)));
            sent += 1;
         end else if (kind < 15) begin
            // truncated command, abandoned by whatever start comes next
            len = $urandom_range(2, 30);
            cut = $urandom_range(0, len - 1);
            send_start(16'(len));
            for (int i = 0; i < cut; i++)
               send_data(8'($urandom_range(255)));
            sent += cut + 1;
         end else if (kind < 18) begin
            wait_drained();
         end else begin
            len = ($urandom_range(99) < 70) ? $urandom_range(0, 12) : $urandom_range(13, 40);
            send_start(16'(len));
            for (int i = 0; i < len; i++)
               send_data(8'($urandom_range(255)));
            sent += len + 1;
         end
      end
   endtask

   initial begin
      req_valid   <= 1'b0;
      req_payload <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty command, stray byte, byte extremes, abandon, full-length header
      send_start(16'd0);
      send_data(8'h5A);
      send_start(16'd3);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'hA5);
      send_start(16'd300);
      send_data(8'h11);
      send_data(8'h22);
      send_start(16'd2);
      send_data(8'h80);
      send_data(8'h7F);
      send_request(make_req(cdfe_pkg::CMD_START, 16'hFFFF, 8'hFF));
      send_data(8'h01);
      send_start(16'd256);
      wait_drained();

      // chunk size zero behaves as one
      csr_write(cdfe_pkg::CSR_IDX_DIRECTION, 32'd0);
      csr_write(cdfe_pkg::CSR_IDX_MAX_CHUNK, 32'd0);
      send_start(16'd3);
      send_data(8'hC3);
      send_data(8'h3C);
      send_data(8'hE7);
      wait_drained();

      // largest chunk size and direction byte
      csr_write(cdfe_pkg::CSR_IDX_DIRECTION, 32'd255);
      csr_write(cdfe_pkg::CSR_IDX_MAX_CHUNK, 32'd1023);
      send_start(16'hFFFF);
      send_data(8'h55);
      send_data(8'hAA);
      send_start(16'd1);
      send_data(8'h99);
      wait_drained();

      // random, sender mostly busy and receiver mostly stalled
      csr_write(cdfe_pkg::CSR_IDX_DIRECTION, $urandom_range(255));
      csr_write(cdfe_pkg::CSR_IDX_MAX_CHUNK, 32'd3);
      run_random(PHASE_REQUESTS);
      wait_drained();

      // random, the other way round
      snd_idle_pct = 85;
      rsp_idle_pct = 8;
      csr_write(cdfe_pkg::CSR_IDX_DIRECTION, $urandom_range(255));
      csr_write(cdfe_pkg::CSR_IDX_MAX_CHUNK, $urandom_range(1, 8));
      run_random(PHASE_REQUESTS);
      wait_drained();

      // random, no idling; receiver holds off first so the input backs up
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      csr_write(cdfe_pkg::CSR_IDX_DIRECTION, $urandom_range(255));
      csr_write(cdfe_pkg::CSR_IDX_MAX_CHUNK, $urandom_range(2, 16));
      hold_cycles <= 80;
      run_random(PHASE_REQUESTS);
      wait_drained();

      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d bytes never came", tracker.pending()));
      if (tracker.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
